// ----- rtl/dmf_pkg.sv -----
// Shared types and constants for the max-flow core.
`default_nettype none
package dmf_pkg;

  localparam int DEF_MAX_NODES = 64;
  localparam int DEF_MAX_EDGES = 256;
  localparam int DEF_CAP_BITS  = 16;

  localparam int NODE_W   = 6;
  localparam int CAP_IN_W = 16;
  localparam int FLOW_W   = 24;
  localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = NODE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINK   = 2'd1;

  localparam logic [NODE_W-1:0] SOURCE_RST = 6'd0;
  localparam logic [NODE_W-1:0] SINK_RST   = 6'd63;

  typedef struct packed {
    logic [NODE_W-1:0]   from_node;
    logic [NODE_W-1:0]   to_node;
    logic [CAP_IN_W-1:0] forward_cap;
    logic [CAP_IN_W-1:0] reverse_cap;
    logic                last_edge;
  } in_beat_t;

  typedef struct packed {
    logic [FLOW_W-1:0] total_flow;
    logic              edges_dropped;
  } out_beat_t;

  typedef struct packed {
    logic      done;
    out_beat_t beat;
  } eng_res_t;

endpackage
`default_nettype wire

// ----- rtl/dinic_max_flow_core.sv -----
// Top level: configuration registers, result register and the flow engine.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------
//  input    | start, busy, in_data                    | beat taken on start & !busy
//  result   | out_valid, out_data                     | one-cycle strobe, no stall
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | valid & ready
//
// An edge is taken in IDLE, which reads the list head, and its two arcs are
// written in LD_A and LD_B; a dropped edge writes no arc. The edge marked last
// then runs the flow sequencer, whose length follows the graph: the BFS, the
// path search and, when a path is augmented, the augmentation, all through
// one memory port each.
// The result shows in the cycle after the run ends. rst_n is synchronous; reset
// needs no clearing pass. The receiver cannot stall; cfg_ready is always high.
`default_nettype none
module dinic_max_flow_core #(
  parameter int MAX_NODES = dmf_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = dmf_pkg::DEF_MAX_EDGES,
  parameter int CAP_BITS  = dmf_pkg::DEF_CAP_BITS
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  output logic                          busy,
  input  dmf_pkg::in_beat_t             in_data,
  output logic                          out_valid,
  output dmf_pkg::out_beat_t            out_data,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [dmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [dmf_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [dmf_pkg::NODE_W-1:0] source_r, source_nxt, sink_r, sink_nxt;
  logic out_valid_r, out_valid_nxt;
  dmf_pkg::out_beat_t out_data_r, out_data_nxt;
  dmf_pkg::eng_res_t  res;
  logic eng_busy;

  dmf_engine #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES),
    .CAP_BITS  (CAP_BITS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (start),
    .in_i     (in_data),
    .source_i (source_r),
    .sink_i   (sink_r),
    .busy_o   (eng_busy),
    .res_o    (res)
  );

  always_comb begin
    source_nxt = source_r;
    sink_nxt = sink_r;
    if (cfg_valid) begin
      case (cfg_index)
        dmf_pkg::CFG_SOURCE: source_nxt = cfg_data;
        dmf_pkg::CFG_SINK:   sink_nxt = cfg_data;
        default: ;
      endcase
    end
    out_valid_nxt = res.done;
    out_data_nxt = res.done ? res.beat : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_r <= dmf_pkg::SOURCE_RST;
      sink_r <= dmf_pkg::SINK_RST;
      out_valid_r <= 1'b0;
      out_data_r <= '0;
    end else begin
      source_r <= source_nxt;
      sink_r <= sink_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r <= out_data_nxt;
    end
  end

  assign busy = eng_busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule
`default_nettype wire

// ----- rtl/dmf_engine.sv -----
// Graph store and Dinic sequencer working on synchronous memories.
`default_nettype none
module dmf_engine #(
  parameter int MAX_NODES = dmf_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = dmf_pkg::DEF_MAX_EDGES,
  parameter int CAP_BITS  = dmf_pkg::DEF_CAP_BITS
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start_i,
  input  dmf_pkg::in_beat_t         in_i,
  input  wire [dmf_pkg::NODE_W-1:0] source_i,
  input  wire [dmf_pkg::NODE_W-1:0] sink_i,
  output logic                      busy_o,
  output dmf_pkg::eng_res_t         res_o
);

  localparam int ARC_SLOTS = 2 * MAX_EDGES;
  localparam int AW    = $clog2(ARC_SLOTS + 1);
  localparam int AIW   = $clog2(ARC_SLOTS);
  localparam int NW    = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int LW    = CNT_W;
  localparam int CW    = CAP_BITS + 1;
  localparam int SW    = ((CW > dmf_pkg::FLOW_W) ? CW : dmf_pkg::FLOW_W) + 1;
  localparam logic [AW-1:0] SENT = AW'(ARC_SLOTS);
  localparam logic [CW-1:0] CAP_MASK = {1'b0, {CAP_BITS{1'b1}}};

  typedef enum logic [4:0] {
    ST_IDLE, ST_LD_A, ST_LD_B, ST_RUN,
    ST_BFS_INIT, ST_BFS_POP, ST_BFS_V, ST_BFS_ES, ST_BFS_EDGE, ST_BFS_CHK,
    ST_PP_TOP, ST_PP_CUR, ST_PP_SCAN, ST_PP_TEST, ST_PP_TEST2, ST_PP_DEC,
    ST_PP_BACK, ST_PP_BACK2,
    ST_AM_RD, ST_AM_CAP, ST_AM_CMP,
    ST_AU_RD, ST_AU_C1, ST_AU_C2, ST_AU_C3,
    ST_DONE
  } state_t;

  // Memories
  logic [CW-1:0] cap_mem  [ARC_SLOTS];
  logic [NW-1:0] head_mem [ARC_SLOTS];
  logic [AW-1:0] next_mem [ARC_SLOTS];
  logic [AW-1:0] first_mem  [MAX_NODES];
  logic [LW-1:0] level_mem  [MAX_NODES];
  logic [AW-1:0] cursor_mem [MAX_NODES];
  logic [NW-1:0] queue_mem  [MAX_NODES];
  logic [AW-1:0] stack_mem  [MAX_NODES];

  logic cap_we, lnk_we, first_we, level_we, cursor_we, queue_we, stack_we;
  logic [AIW-1:0] cap_wa, lnk_wa, cap_ra, head_ra, next_ra;
  logic [CW-1:0]  cap_wd, cap_q;
  logic [NW-1:0]  head_wd, head_q;
  logic [AW-1:0]  next_wd, next_q;
  logic [NW-1:0]  first_wa, first_ra, level_wa, level_ra, cursor_wa, cursor_ra;
  logic [NW-1:0]  queue_wa, queue_ra, stack_wa, stack_ra;
  logic [AW-1:0]  first_wd, first_q, cursor_wd, cursor_q, stack_wd, stack_q;
  logic [LW-1:0]  level_wd, level_q;
  logic [NW-1:0]  queue_wd, queue_q;

  always_ff @(posedge clk) begin
    if (cap_we) cap_mem[cap_wa] <= cap_wd;
    cap_q <= cap_mem[cap_ra];
  end

  always_ff @(posedge clk) begin
    if (lnk_we) begin
      head_mem[lnk_wa] <= head_wd;
      next_mem[lnk_wa] <= next_wd;
    end
    head_q <= head_mem[head_ra];
    next_q <= next_mem[next_ra];
  end

  always_ff @(posedge clk) begin
    if (first_we) first_mem[first_wa] <= first_wd;
    first_q <= first_mem[first_ra];
  end

  always_ff @(posedge clk) begin
    if (level_we) level_mem[level_wa] <= level_wd;
    level_q <= level_mem[level_ra];
  end

  always_ff @(posedge clk) begin
    if (cursor_we) cursor_mem[cursor_wa] <= cursor_wd;
    cursor_q <= cursor_mem[cursor_ra];
  end

  always_ff @(posedge clk) begin
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    queue_q <= queue_mem[queue_ra];
  end

  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_wa] <= stack_wd;
    stack_q <= stack_mem[stack_ra];
  end

  // Control and working registers
  state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic ovf_r, ovf_nxt;
  logic [MAX_NODES-1:0] fvalid_r, fvalid_nxt;
  logic [MAX_NODES-1:0] reached_r, reached_nxt;
  logic [MAX_NODES-1:0] cvalid_r, cvalid_nxt;
  logic [NW-1:0] u_r, u_nxt, t_r, t_nxt, node_r, node_nxt, w_r, w_nxt;
  logic [CW-1:0] fc_r, fc_nxt, rc_r, rc_nxt, b_r, b_nxt;
  logic last_r, last_nxt, found_r, found_nxt, capnz_r, capnz_nxt;
  logic [AW-1:0] e_r, e_nxt, nx_r, nx_nxt;
  logic [LW-1:0] lv_r, lv_nxt;
  logic [CNT_W-1:0] rd_r, rd_nxt, wr_r, wr_nxt, depth_r, depth_nxt, i_r, i_nxt;
  logic [dmf_pkg::FLOW_W-1:0] total_r, total_nxt;

  logic [NW-1:0] s_n, t_n;
  logic          term_ok;
  logic          edge_ok;
  logic [AW-1:0] first_eff;
  logic [AW-1:0] e_x1;
  logic [SW-1:0] sum;

  assign s_n = NW'(source_i);
  assign t_n = NW'(sink_i);
  assign term_ok = (32'(source_i) < 32'(MAX_NODES)) && (32'(sink_i) < 32'(MAX_NODES))
                   && (source_i != sink_i);
  assign edge_ok = (32'(in_i.from_node) < 32'(MAX_NODES))
                   && (32'(in_i.to_node) < 32'(MAX_NODES))
                   && (32'(cnt_r) + 32'd2 <= 32'(ARC_SLOTS));
  assign first_eff = fvalid_r[node_r] ? first_q : SENT;
  assign e_x1 = e_r ^ AW'(1);
  assign sum = SW'(total_r) + SW'(b_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;  ovf_nxt = ovf_r;
    fvalid_nxt = fvalid_r;  reached_nxt = reached_r;  cvalid_nxt = cvalid_r;
    u_nxt = u_r;  t_nxt = t_r;  node_nxt = node_r;  w_nxt = w_r;
    fc_nxt = fc_r;  rc_nxt = rc_r;  b_nxt = b_r;
    last_nxt = last_r;  found_nxt = found_r;  capnz_nxt = capnz_r;
    e_nxt = e_r;  nx_nxt = nx_r;  lv_nxt = lv_r;
    rd_nxt = rd_r;  wr_nxt = wr_r;  depth_nxt = depth_r;  i_nxt = i_r;
    total_nxt = total_r;

    cap_we = 1'b0;  cap_wa = e_r[AIW-1:0];  cap_wd = '0;  cap_ra = e_r[AIW-1:0];
    lnk_we = 1'b0;  lnk_wa = cnt_r[AIW-1:0];  head_wd = '0;  next_wd = '0;
    head_ra = e_r[AIW-1:0];  next_ra = e_r[AIW-1:0];
    first_we = 1'b0;  first_wa = u_r;  first_wd = cnt_r;  first_ra = node_r;
    level_we = 1'b0;  level_wa = t_r;  level_wd = '0;  level_ra = node_r;
    cursor_we = 1'b0;  cursor_wa = node_r;  cursor_wd = e_r;  cursor_ra = node_r;
    queue_we = 1'b0;  queue_wa = wr_r[NW-1:0];  queue_wd = t_r;
    queue_ra = rd_r[NW-1:0];
    stack_we = 1'b0;  stack_wa = depth_r[NW-1:0];  stack_wd = e_r;
    stack_ra = i_r[NW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (start_i) begin
          u_nxt  = NW'(in_i.from_node);
          node_nxt = NW'(in_i.to_node);
          fc_nxt = CW'(in_i.forward_cap) & CAP_MASK;
          rc_nxt = CW'(in_i.reverse_cap) & CAP_MASK;
          last_nxt = in_i.last_edge;
          if (edge_ok) begin
            first_ra = NW'(in_i.from_node);
            state_nxt = ST_LD_A;
          end else begin
            ovf_nxt = 1'b1;
            if (in_i.last_edge) state_nxt = ST_RUN;
          end
        end
      end
      ST_LD_A: begin
        // forward arc: tail u, head v
        lnk_we = 1'b1;
        lnk_wa = cnt_r[AIW-1:0];
        head_wd = node_r;
        next_wd = fvalid_r[u_r] ? first_q : SENT;
        cap_we = 1'b1;
        cap_wa = cnt_r[AIW-1:0];
        cap_wd = fc_r;
        first_we = 1'b1;
        first_wa = u_r;
        first_wd = cnt_r;
        fvalid_nxt[u_r] = 1'b1;
        first_ra = node_r;
        state_nxt = ST_LD_B;
      end
      ST_LD_B: begin
        // reverse arc; forward the list head just written for a self loop
        lnk_we = 1'b1;
        lnk_wa = AIW'(cnt_r + AW'(1));
        head_wd = u_r;
        next_wd = (node_r == u_r) ? cnt_r : first_eff;
        cap_we = 1'b1;
        cap_wa = AIW'(cnt_r + AW'(1));
        cap_wd = rc_r;
        first_we = 1'b1;
        first_wa = node_r;
        first_wd = cnt_r + AW'(1);
        fvalid_nxt[node_r] = 1'b1;
        cnt_nxt = cnt_r + AW'(2);
        state_nxt = last_r ? ST_RUN : ST_IDLE;
      end
      ST_RUN: begin
        total_nxt = '0;
        t_nxt = t_n;
        state_nxt = term_ok ? ST_BFS_INIT : ST_DONE;
      end
      ST_BFS_INIT: begin
        reached_nxt = '0;
        reached_nxt[t_r] = 1'b1;
        queue_we = 1'b1;
        queue_wa = '0;
        queue_wd = t_r;
        level_we = 1'b1;
        level_wa = t_r;
        level_wd = '0;
        rd_nxt = '0;
        wr_nxt = CNT_W'(1);
        state_nxt = ST_BFS_POP;
      end
      ST_BFS_POP: begin
        if (rd_r < wr_r) begin
          queue_ra = rd_r[NW-1:0];
          rd_nxt = rd_r + CNT_W'(1);
          state_nxt = ST_BFS_V;
        end else if (reached_r[s_n]) begin
          cvalid_nxt = '0;
          node_nxt = s_n;
          depth_nxt = '0;
          state_nxt = ST_PP_TOP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_BFS_V: begin
        node_nxt = queue_q;
        first_ra = queue_q;
        level_ra = queue_q;
        state_nxt = ST_BFS_ES;
      end
      ST_BFS_ES: begin
        e_nxt = first_eff;
        lv_nxt = level_q;
        state_nxt = ST_BFS_EDGE;
      end
      ST_BFS_EDGE: begin
        if (e_r < cnt_r) begin
          head_ra = e_r[AIW-1:0];
          next_ra = e_r[AIW-1:0];
          cap_ra = e_x1[AIW-1:0];
          state_nxt = ST_BFS_CHK;
        end else begin
          state_nxt = ST_BFS_POP;
        end
      end
      ST_BFS_CHK: begin
        if ((cap_q != '0) && !reached_r[head_q] && (wr_r < CNT_W'(MAX_NODES))) begin
          reached_nxt[head_q] = 1'b1;
          level_we = 1'b1;
          level_wa = head_q;
          level_wd = LW'(lv_r + LW'(1));
          queue_we = 1'b1;
          queue_wa = wr_r[NW-1:0];
          queue_wd = head_q;
          wr_nxt = wr_r + CNT_W'(1);
        end
        e_nxt = next_q;
        state_nxt = ST_BFS_EDGE;
      end
      ST_PP_TOP: begin
        if (node_r == t_r) begin
          i_nxt = '0;
          b_nxt = '1;
          state_nxt = ST_AM_RD;
        end else begin
          cursor_ra = node_r;
          first_ra = node_r;
          level_ra = node_r;
          state_nxt = ST_PP_CUR;
        end
      end
      ST_PP_CUR: begin
        e_nxt = cvalid_r[node_r] ? cursor_q : first_eff;
        lv_nxt = level_q;
        state_nxt = ST_PP_SCAN;
      end
      ST_PP_SCAN: begin
        if (e_r < cnt_r) begin
          head_ra = e_r[AIW-1:0];
          next_ra = e_r[AIW-1:0];
          cap_ra = e_r[AIW-1:0];
          state_nxt = ST_PP_TEST;
        end else begin
          found_nxt = 1'b0;
          state_nxt = ST_PP_DEC;
        end
      end
      ST_PP_TEST: begin
        w_nxt = head_q;
        capnz_nxt = (cap_q != '0);
        nx_nxt = next_q;
        level_ra = head_q;
        state_nxt = ST_PP_TEST2;
      end
      ST_PP_TEST2: begin
        if (capnz_r && reached_r[w_r] && (lv_r != '0) && (level_q == lv_r - LW'(1))) begin
          found_nxt = 1'b1;
          state_nxt = ST_PP_DEC;
        end else begin
          e_nxt = nx_r;
          state_nxt = ST_PP_SCAN;
        end
      end
      ST_PP_DEC: begin
        cursor_we = 1'b1;
        cursor_wa = node_r;
        cursor_wd = e_r;
        cvalid_nxt[node_r] = 1'b1;
        if (found_r && (depth_r < CNT_W'(MAX_NODES))) begin
          stack_we = 1'b1;
          stack_wa = depth_r[NW-1:0];
          stack_wd = e_r;
          depth_nxt = depth_r + CNT_W'(1);
          node_nxt = w_r;
          state_nxt = ST_PP_TOP;
        end else if (depth_r == '0) begin
          // blocked: rebuild levels
          state_nxt = ST_BFS_INIT;
        end else begin
          depth_nxt = depth_r - CNT_W'(1);
          stack_ra = NW'(depth_r - CNT_W'(1));
          state_nxt = ST_PP_BACK;
        end
      end
      ST_PP_BACK: begin
        head_ra = AIW'(stack_q ^ AW'(1));
        next_ra = stack_q[AIW-1:0];
        state_nxt = ST_PP_BACK2;
      end
      ST_PP_BACK2: begin
        node_nxt = head_q;
        cursor_we = 1'b1;
        cursor_wa = head_q;
        cursor_wd = next_q;
        cvalid_nxt[head_q] = 1'b1;
        state_nxt = ST_PP_TOP;
      end
      ST_AM_RD: begin
        if (i_r < depth_r) begin
          stack_ra = i_r[NW-1:0];
          i_nxt = i_r + CNT_W'(1);
          state_nxt = ST_AM_CAP;
        end else begin
          i_nxt = '0;
          state_nxt = ST_AU_RD;
        end
      end
      ST_AM_CAP: begin
        cap_ra = stack_q[AIW-1:0];
        state_nxt = ST_AM_CMP;
      end
      ST_AM_CMP: begin
        if (cap_q < b_r) b_nxt = cap_q;
        state_nxt = ST_AM_RD;
      end
      ST_AU_RD: begin
        if (i_r < depth_r) begin
          stack_ra = i_r[NW-1:0];
          i_nxt = i_r + CNT_W'(1);
          state_nxt = ST_AU_C1;
        end else begin
          total_nxt = (sum > SW'(dmf_pkg::FLOW_MAX)) ? dmf_pkg::FLOW_MAX
                                                     : sum[dmf_pkg::FLOW_W-1:0];
          node_nxt = s_n;
          depth_nxt = '0;
          state_nxt = ST_PP_TOP;
        end
      end
      ST_AU_C1: begin
        e_nxt = stack_q;
        cap_ra = stack_q[AIW-1:0];
        state_nxt = ST_AU_C2;
      end
      ST_AU_C2: begin
        cap_we = 1'b1;
        cap_wa = e_r[AIW-1:0];
        cap_wd = cap_q - b_r;
        cap_ra = e_x1[AIW-1:0];
        state_nxt = ST_AU_C3;
      end
      ST_AU_C3: begin
        cap_we = 1'b1;
        cap_wa = e_x1[AIW-1:0];
        cap_wd = cap_q + b_r;
        state_nxt = ST_AU_RD;
      end
      ST_DONE: begin
        // drop the graph
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
        fvalid_nxt = '0;
        reached_nxt = '0;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;  ovf_r <= 1'b0;
      fvalid_r <= '0;  reached_r <= '0;  cvalid_r <= '0;
      u_r <= '0;  t_r <= '0;  node_r <= '0;  w_r <= '0;
      fc_r <= '0;  rc_r <= '0;  b_r <= '0;
      last_r <= 1'b0;  found_r <= 1'b0;  capnz_r <= 1'b0;
      e_r <= '0;  nx_r <= '0;  lv_r <= '0;
      rd_r <= '0;  wr_r <= '0;  depth_r <= '0;  i_r <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;  ovf_r <= ovf_nxt;
      fvalid_r <= fvalid_nxt;  reached_r <= reached_nxt;  cvalid_r <= cvalid_nxt;
      u_r <= u_nxt;  t_r <= t_nxt;  node_r <= node_nxt;  w_r <= w_nxt;
      fc_r <= fc_nxt;  rc_r <= rc_nxt;  b_r <= b_nxt;
      last_r <= last_nxt;  found_r <= found_nxt;  capnz_r <= capnz_nxt;
      e_r <= e_nxt;  nx_r <= nx_nxt;  lv_r <= lv_nxt;
      rd_r <= rd_nxt;  wr_r <= wr_nxt;  depth_r <= depth_nxt;  i_r <= i_nxt;
      total_r <= total_nxt;
    end
  end

  assign busy_o = (state_r != ST_IDLE);
  assign res_o.done = (state_r == ST_DONE);
  assign res_o.beat.total_flow = total_r;
  assign res_o.beat.edges_dropped = ovf_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cnt_r) <= 32'(ARC_SLOTS)) && !cnt_r[0])
    else $error("arc count out of range");
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    rd_r <= wr_r)
    else $error("queue read passed write");
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(depth_r) <= 32'(MAX_NODES))
    else $error("path stack overflow");
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    res_o.done |=> (cnt_r == '0) && !ovf_r && !busy_o)
    else $error("graph not emptied after result");

endmodule
`default_nettype wire
